### hdl/lrubp_pkg.sv
// Shared constants, types and codes of the LRU binding pool.
`default_nettype none
package lrubp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int KEY_BITS   = 32;
  localparam int STAMP_BITS = 32;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int CAP_W      = 5;

  // Outcome codes carried on the result channel
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_ALLOC = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    key_t   key;
    stamp_t stamp;
  } entry_t;

  typedef struct packed {
    logic  clear;
    logic  smp_vld;
    slot_t smp_idx;
  } scan_ctl_t;

  typedef struct packed {
    logic  found;
    slot_t hit_idx;
    slot_t min_idx;
    key_t  min_key;
  } scan_res_t;

endpackage
`default_nettype wire

### hdl/lrubp_if.sv
// Valid/ready channel interfaces for the request and result transfers.
`default_nettype none
interface lrubp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] format_key;

  modport source (output valid, output format_key, input ready);
  modport sink   (input valid, input format_key, output ready);
endinterface

interface lrubp_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  slot;
  logic [1:0]  outcome;
  logic [31:0] evicted_key;
  logic [4:0]  occupied;

  modport source (output valid, output hit, output slot, output outcome,
                  output evicted_key, output occupied, input ready);
  modport sink   (input valid, input hit, input slot, input outcome,
                  input evicted_key, input occupied, output ready);
endinterface
`default_nettype wire

### hdl/lru_binding_pool_core.sv
// LRU binding pool top level: sequencer, use clock, fill count and result register.
// The sweep reads one filled slot from the store per cycle; a new input transfer is
//   taken only once the result of the last is in the output register, even while
//   that result waits.
// Reset (synchronous, rst_n low): pool empty, use clock zero, capacity 16.
`default_nettype none
module lru_binding_pool_core
  import lrubp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  lrubp_in_if.sink              in_ch,
  lrubp_out_if.source           out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  cnt_t             fill_r, fill_nxt;
  stamp_t           use_clk_r, use_clk_nxt;
  key_t             key_r, key_nxt;
  stamp_t           stamp_r, stamp_nxt;
  cnt_t             iss_r, iss_nxt;
  logic             smp_vld_r, smp_vld_nxt;
  slot_t            smp_idx_r, smp_idx_nxt;

  logic             ov_r, ov_nxt;
  logic             o_hit_r, o_hit_nxt;
  slot_t            o_slot_r, o_slot_nxt;
  logic [1:0]       o_outc_r, o_outc_nxt;
  key_t             o_evk_r, o_evk_nxt;
  cnt_t             o_occ_r, o_occ_nxt;

  logic             in_xfer;
  logic             out_free;
  cnt_t             eff_cap;
  logic             wr_en;
  slot_t            wr_idx;
  scan_ctl_t        scan_ctl;
  scan_res_t        scan_res;
  entry_t           rd_data;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Clamp the capacity register into 1..POOL_DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_r) > POOL_DEPTH) begin
      eff_cap = CNT_W'(POOL_DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  // Sequencer: accept, sweep the filled slots, then resolve and write back
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    use_clk_nxt = use_clk_r;
    key_nxt     = key_r;
    stamp_nxt   = stamp_r;
    iss_nxt     = iss_r;
    smp_vld_nxt = 1'b0;
    smp_idx_nxt = smp_idx_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_hit_nxt   = o_hit_r;
    o_slot_nxt  = o_slot_r;
    o_outc_nxt  = o_outc_r;
    o_evk_nxt   = o_evk_r;
    o_occ_nxt   = o_occ_r;
    wr_en       = 1'b0;
    wr_idx      = scan_res.hit_idx;
    scan_ctl    = '{clear: 1'b0, smp_vld: smp_vld_r, smp_idx: smp_idx_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt   = in_ch.format_key[KEY_BITS-1:0];
          stamp_nxt = use_clk_r;
          // advance the use clock, hold once saturated
          if (use_clk_r != '1) begin
            use_clk_nxt = use_clk_r + STAMP_BITS'(1);
          end
          iss_nxt        = '0;
          scan_ctl.clear = 1'b1;
          state_nxt      = (fill_r == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read per cycle; the sample follows in the cycle after
        smp_vld_nxt = 1'b1;
        smp_idx_nxt = iss_r[SLOT_W-1:0];
        iss_nxt     = iss_r + CNT_W'(1);
        if (iss_r == fill_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last sample is folded in this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          wr_en      = 1'b1;
          ov_nxt     = 1'b1;
          o_evk_nxt  = '0;
          o_hit_nxt  = scan_res.found;
          if (scan_res.found) begin
            wr_idx     = scan_res.hit_idx;
            o_outc_nxt = OUT_HIT;
          end else if (fill_r < eff_cap) begin
            wr_idx     = fill_r[SLOT_W-1:0];
            fill_nxt   = fill_r + CNT_W'(1);
            o_outc_nxt = OUT_ALLOC;
          end else begin
            wr_idx     = scan_res.min_idx;
            o_evk_nxt  = scan_res.min_key;
            o_outc_nxt = OUT_EVICT;
          end
          o_slot_nxt = wr_idx;
          o_occ_nxt  = fill_nxt;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  lrubp_pool u_pool (
    .clk     (clk),
    .rd_addr (iss_r[SLOT_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data ('{key: key_r, stamp: stamp_r})
  );

  lrubp_scan u_scan (
    .clk (clk),
    .ctl (scan_ctl),
    .smp (rd_data),
    .key (key_r),
    .res (scan_res)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cap_r     <= CAP_W'(POOL_DEPTH);
      fill_r    <= '0;
      use_clk_r <= '0;
      smp_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      use_clk_r <= use_clk_nxt;
      smp_vld_r <= smp_vld_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    stamp_r   <= stamp_nxt;
    iss_r     <= iss_nxt;
    smp_idx_r <= smp_idx_nxt;
    o_hit_r   <= o_hit_nxt;
    o_slot_r  <= o_slot_nxt;
    o_outc_r  <= o_outc_nxt;
    o_evk_r   <= o_evk_nxt;
    o_occ_r   <= o_occ_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.hit         = o_hit_r;
  assign out_ch.slot        = o_slot_r;
  assign out_ch.outcome     = o_outc_r;
  assign out_ch.evicted_key = o_evk_r;
  assign out_ch.occupied    = o_occ_r;

  // Busy straight after taking a request
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input accepted again while an item is in flight");

  // Hit flag agrees with the outcome code
  a_hit_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (o_hit_r == (o_outc_r == OUT_HIT)))
    else $error("hit flag and outcome disagree");

  // Evicted key is only reported on a replacement
  a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_outc_r != OUT_EVICT) |-> (o_evk_r == '0))
    else $error("evicted key set without a replacement");

  // Fill count never passes the pool depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= POOL_DEPTH)
    else $error("fill count beyond pool depth");

endmodule
`default_nettype wire

### hdl/lrubp_pool.sv
// Slot store: key and stamp memory with one registered read and one write port.
`default_nettype none
module lrubp_pool
  import lrubp_pkg::*;
(
  input  wire logic   clk,
  input  wire slot_t  rd_addr,
  output entry_t      rd_data,
  input  wire logic   wr_en,
  input  wire slot_t  wr_addr,
  input  wire entry_t wr_data
);

  entry_t mem [POOL_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hdl/lrubp_scan.sv
// Shared compare unit: one slot per cycle for key match and oldest stamp.
`default_nettype none
module lrubp_scan
  import lrubp_pkg::*;
(
  input  wire logic      clk,
  input  wire scan_ctl_t ctl,
  input  wire entry_t    smp,
  input  wire key_t      key,
  output scan_res_t      res
);

  logic   found_r, found_nxt;
  slot_t  hit_idx_r, hit_idx_nxt;
  logic   min_vld_r, min_vld_nxt;
  stamp_t min_stamp_r, min_stamp_nxt;
  slot_t  min_idx_r, min_idx_nxt;
  key_t   min_key_r, min_key_nxt;

  always_comb begin
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    min_vld_nxt   = min_vld_r;
    min_stamp_nxt = min_stamp_r;
    min_idx_nxt   = min_idx_r;
    min_key_nxt   = min_key_r;
    if (ctl.clear) begin
      found_nxt   = 1'b0;
      min_vld_nxt = 1'b0;
    end else if (ctl.smp_vld) begin
      // keep the first match only
      if (!found_r && smp.key == key) begin
        found_nxt   = 1'b1;
        hit_idx_nxt = ctl.smp_idx;
      end
      // strict less keeps the lowest index among equal stamps
      if (!min_vld_r || smp.stamp < min_stamp_r) begin
        min_vld_nxt   = 1'b1;
        min_stamp_nxt = smp.stamp;
        min_idx_nxt   = ctl.smp_idx;
        min_key_nxt   = smp.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r     <= found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    min_vld_r   <= min_vld_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_idx_r   <= min_idx_nxt;
    min_key_r   <= min_key_nxt;
  end

  assign res = '{found: found_r, hit_idx: hit_idx_r, min_idx: min_idx_r,
                 min_key: min_key_r};

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the LRU binding pool: lookup predictor, driver and monitor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import lrubp_pkg::*;

  // One expected lookup result, laid out as the result channel carries it
  typedef struct packed {
    logic             hit;
    slot_t            slot;
    logic [1:0]       outcome;
    key_t             evicted;
    logic [CAP_W-1:0] occupied;
  } lookup_result_t;

  // Capacities visited by the random phases: extremes, clamped values and a
  // few ordinary sizes
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 48;
  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
    '{5'd1, 5'd16, 5'd5, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8};
  localparam int LONG_STALL_CYCLES = 300;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lrubp_in_if  in_ch ();
  lrubp_out_if out_ch ();

  lru_binding_pool_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Keys waiting to be offered, and lookup results still owed by the block
  key_t           pending_keys [$];
  lookup_result_t expected_results [$];

  // Shadow copy of the pool: keys, last-use stamps, fill level, use clock and
  // the capacity register as last written
  key_t             pool_keys   [POOL_DEPTH];
  stamp_t           pool_stamps [POOL_DEPTH];
  int               pool_fill = 0;
  stamp_t           pool_clock = '0;
  logic [CAP_W-1:0] model_capacity = CAP_W'(POOL_DEPTH);

  // Traffic shaping: calm turns idling off on both sides, sink_hold keeps the
  // receiver from taking any transfer during the long stall
  logic calm = 1'b0;
  logic sink_hold = 1'b0;
  logic stall_trigger = 1'b0;

  int mismatches = 0;
  int result_count = 0;

  // Work out the result of one lookup and advance the shadow pool.
  function automatic lookup_result_t predict_lookup(input key_t key);
    lookup_result_t res;
    stamp_t stamp;
    stamp_t oldest;
    int limit;
    int idx;
    logic found;
    // The lookup takes the current clock as its stamp; the clock then holds
    // once it reaches its maximum
    stamp = pool_clock;
    if (pool_clock != '1) pool_clock = pool_clock + 1'b1;
    // Clamp the register: zero acts as one, anything beyond the pool as full depth
    if (model_capacity == '0) limit = 1;
    else if (model_capacity > POOL_DEPTH) limit = POOL_DEPTH;
    else limit = int'(model_capacity);
    found = 1'b0;
    idx = 0;
    // Search every filled slot, even those above a lowered capacity
    for (int i = 0; i < pool_fill; i++) begin
      if (!found && pool_keys[i] == key) begin
        found = 1'b1;
        idx = i;
      end
    end
    res.evicted = '0;
    if (found) begin
      res.outcome = OUT_HIT;
    end else if (pool_fill < limit) begin
      idx = pool_fill;
      pool_fill++;
      res.outcome = OUT_ALLOC;
    end else begin
      // Oldest stamp loses; strict compare keeps the lowest index on a tie
      oldest = pool_stamps[0];
      idx = 0;
      for (int i = 1; i < pool_fill; i++) begin
        if (pool_stamps[i] < oldest) begin
          oldest = pool_stamps[i];
          idx = i;
        end
      end
      res.evicted = pool_keys[idx];
      res.outcome = OUT_EVICT;
    end
    pool_keys[idx] = key;
    pool_stamps[idx] = stamp;
    res.hit = found;
    res.slot = slot_t'(idx);
    res.occupied = CAP_W'(pool_fill);
    return res;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
               result_count, field, got, want);
  endtask

  // Block until no key is queued or on offer and every result has arrived.
  // Sample on the falling edge, clear of all updates made at the rising one.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_keys.size() != 0 || in_ch.valid || expected_results.size() != 0);
  endtask

  // Write the capacity register with the pool idle, then mirror it.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    model_capacity = value;
  endtask

  // Driver: offer queued keys, keep valid and the key steady until the
  // transfer, and predict each lookup at the edge on which it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_lookup(in_ch.format_key));
      // Only move on once the current offer has gone or there is none
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_keys.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          in_ch.format_key <= pending_keys.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction and
  // toggle ready at random unless held off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", {27'd0, out_ch.occupied}, '0);
        end else begin : compare
          lookup_result_t want;
          want = expected_results.pop_front();
          if (out_ch.hit !== want.hit)
            report_mismatch("hit", 32'(out_ch.hit), 32'(want.hit));
          if (out_ch.slot !== want.slot)
            report_mismatch("slot", 32'(out_ch.slot), 32'(want.slot));
          if (out_ch.outcome !== want.outcome)
            report_mismatch("outcome", 32'(out_ch.outcome), 32'(want.outcome));
          if (out_ch.evicted_key !== want.evicted)
            report_mismatch("evicted_key", out_ch.evicted_key, want.evicted);
          if (out_ch.occupied !== want.occupied)
            report_mismatch("occupied", 32'(out_ch.occupied), 32'(want.occupied));
        end
      end
      out_ch.ready <= !sink_hold && (calm || $urandom_range(0, 99) >= 27);
    end
  end

  // Long receiver stall: once triggered, hold ready low so the output register
  // fills and the input side backs up, then release it.
  initial begin : long_stall
    wait (stall_trigger);
    @(negedge clk);
    sink_hold = 1'b1;
    repeat (LONG_STALL_CYCLES) @(negedge clk);
    sink_hold = 1'b0;
  end

  // Stimulus: reset, directed lookups, then random phases at varied capacities.
  initial begin : stimulus
    key_t working_set [$];
    int set_size;
    // Drive every input to a known level from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.format_key = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset capacity: allocate, hit on both extreme keys, single-bit keys
    pending_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                     32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    // Lower the capacity under the fill level: nothing dropped, misses evict
    write_capacity(5'd3);
    pending_keys = '{32'h1234_5678, 32'h0000_0000, 32'h8000_0000};
    // Zero capacity behaves as one: still no append, misses keep evicting
    write_capacity(5'd0);
    pending_keys = '{32'hFEDC_BA98, 32'hFEDC_BA98, 32'h0000_0000};
    // Out-of-range capacity clamps to full depth: appending resumes
    write_capacity(5'd31);
    pending_keys = '{32'h0F0F_0F0F, 32'hF0F0_F0F0};

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(PHASE_CAPS[p]);
      // Phase two runs without any idling on either side
      calm = (p == 1);
      // Draw a working set of 1 to 24 keys so hits and evictions mix
      set_size = $urandom_range(1, 24);
      working_set.delete();
      for (int k = 0; k < set_size; k++) working_set.push_back($urandom);
      if (p == 3) stall_trigger = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender half way through until the pool has answered all
        if (p == 5 && n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 99) < 15)
          pending_keys.push_back($urandom);
        else
          pending_keys.push_back(working_set[$urandom_range(0, set_size - 1)]);
      end
    end

    wait_drained();
    // Allow a full-pool lookup time for any stray result to show up
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS lru_binding_pool_core");
    end else begin
      $display("FAIL lru_binding_pool_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("FAIL lru_binding_pool_core");
    $finish;
  end

endmodule
`default_nettype wire
